[design/ech_pkg.sv]
// Shared types and constants for the event cut charge histogram unit.
package ech_pkg;

    localparam int CHARGE_W   = 20;
    localparam int CHANNEL_W  = 8;
    localparam int NOISE_W    = 12;
    localparam int BASELINE_W = 18;
    localparam int WINDOW_W   = 16;
    localparam int SELECT_W   = 8;
    localparam int HIT_W      = 8;
    localparam int RESULT_W   = 32;
    localparam int ADDR_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int DEF_NUM_BINS    = 200;
    localparam int DEF_BIN_WIDTH   = 800;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CHANNEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_LOW        = 3'd4;

    localparam logic [CHANNEL_W-1:0]  RST_WANTED_CHANNEL  = 8'd3;
    localparam logic [NOISE_W-1:0]    RST_NOISE_LIMIT     = 12'd109;
    localparam logic [BASELINE_W-1:0] RST_BASELINE_CENTER = 18'd56800;
    localparam logic [WINDOW_W-1:0]   RST_BASELINE_WINDOW = 16'd80;
    localparam logic [CHARGE_W-1:0]   RST_HIST_LOW        = 20'hF8300;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic                         command;
        logic [CHANNEL_W-1:0]         channel;
        logic signed [CHARGE_W-1:0]   charge;
        logic [NOISE_W-1:0]           noise;
        logic [BASELINE_W-1:0]        baseline;
        logic [SELECT_W-1:0]          bin_select;
    } ech_in_t;

    typedef struct packed {
        logic                 accepted;
        logic [HIT_W-1:0]     bin_hit;
        logic [RESULT_W-1:0]  bin_count;
    } ech_out_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0]        wanted_channel;
        logic [NOISE_W-1:0]          noise_limit;
        logic [BASELINE_W-1:0]       baseline_center;
        logic [WINDOW_W-1:0]         baseline_window;
        logic signed [CHARGE_W-1:0]  hist_low;
    } ech_cfg_t;

    // One operation handed from the front to the back
    typedef struct packed {
        logic               rd;     // read back a bin
        logic               ok;     // bin address is inside the store
        logic               acc;    // counted event: increment the bin
        logic [ADDR_W-1:0]  bin;
    } ech_op_t;

endpackage

[design/ech_ram.sv]
// Generic simple dual-port RAM with registered read.
module ech_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/ech_front.sv]
// Front part: accepts items, applies the cuts and finds the bin.
module ech_front #(
    parameter int NUM_BINS  = ech_pkg::DEF_NUM_BINS,
    parameter int BIN_WIDTH = ech_pkg::DEF_BIN_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ech_pkg::ech_in_t item,
    input  ech_pkg::ech_cfg_t cfg,
    output ech_pkg::ech_op_t op,
    output logic             op_push,
    input  logic             op_full
);

    import ech_pkg::*;

    // Reciprocal of BIN_WIDTH, exact for every offset below 2^CHARGE_W
    localparam int DIV_S   = CHARGE_W + $clog2(BIN_WIDTH);
    localparam int RECIP_W = CHARGE_W + 2;
    localparam int PROD_W  = CHARGE_W + RECIP_W;
    localparam int QUO_W   = PROD_W - DIV_S;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_S) + 64'(BIN_WIDTH) - 64'd1) / 64'(BIN_WIDTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CHARGE_W-1:0] dvd_reg, dvd_next;
    ech_op_t             op_reg, op_next;

    logic                accept;
    logic [BASELINE_W:0] dev;
    logic [BASELINE_W:0] abs_dev;
    logic                pass;
    logic [CHARGE_W:0]   offs;
    logic [PROD_W-1:0]   prod;
    logic [QUO_W-1:0]    quo;
    logic [ADDR_W-1:0]   bin_idx;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        dev     = {1'b0, item.baseline} - {1'b0, cfg.baseline_center};
        abs_dev = dev[BASELINE_W] ? (~dev + 1'b1) : dev;
        pass    = (item.channel == cfg.wanted_channel)
               && (item.noise <= cfg.noise_limit)
               && (abs_dev < (BASELINE_W + 1)'(cfg.baseline_window));
        offs    = {item.charge[CHARGE_W-1], item.charge}
                - {cfg.hist_low[CHARGE_W-1], cfg.hist_low};
    end

    // Bin number from the offset by multiplying with the reciprocal
    always_comb
    begin
        prod = {{RECIP_W{1'b0}}, dvd_reg} * {{CHARGE_W{1'b0}}, RECIP};
        quo  = prod[PROD_W-1:DIV_S];
        if (32'(quo) >= NUM_BINS)
        begin
            bin_idx = ADDR_W'(NUM_BINS + 1);
        end
        else
        begin
            bin_idx = ADDR_W'(quo) + ADDR_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        op_next    = op_reg;
        op_push    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PUSH;
                    op_next    = '0;
                    if (item.command == CMD_READ)
                    begin
                        op_next.rd  = 1'b1;
                        op_next.ok  = (32'(item.bin_select) < NUM_BINS + 2);
                        op_next.bin = ADDR_W'(item.bin_select);
                    end
                    else if (pass && offs[CHARGE_W])
                    begin
                        op_next.ok  = 1'b1;
                        op_next.acc = 1'b1;
                    end
                    else if (pass)
                    begin
                        state_next = ST_DIV;
                        dvd_next   = offs[CHARGE_W-1:0];
                    end
                end
            end
            ST_DIV:
            begin
                state_next  = ST_PUSH;
                op_next     = '0;
                op_next.ok  = 1'b1;
                op_next.acc = 1'b1;
                op_next.bin = bin_idx;
            end
            ST_PUSH:
            begin
                // hold until the queue has room
                if (!op_full)
                begin
                    op_push    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign op = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        op_reg  <= op_next;
    end

endmodule

[design/ech_queue.sv]
// Two-entry queue of operations between the front and the back.
module ech_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ech_pkg::ech_op_t wdata,
    output logic             full,
    input  logic             pop,
    output ech_pkg::ech_op_t rdata,
    output logic             empty
);

    import ech_pkg::*;

    ech_op_t    slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[design/ech_back.sv]
// Back part: clears the counter store, then reads and updates bin counters.
module ech_back #(
    parameter int NUM_BINS    = 200,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ech_pkg::ech_op_t  op,
    input  logic              op_empty,
    output logic              op_pop,
    output logic              clearing,
    output logic              done,
    output ech_pkg::ech_out_t result
);

    import ech_pkg::*;

    localparam int TOTAL = NUM_BINS + 2;
    localparam int IW    = $clog2(TOTAL);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [IW-1:0]          clr_reg, clr_next;
    ech_op_t                cur_reg;

    logic                   we;
    logic [IW-1:0]          waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [COUNT_WIDTH-1:0] rdata;
    logic [COUNT_WIDTH-1:0] inc;

    ech_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TOTAL)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (op.bin[IW-1:0]),
        .rdata (rdata)
    );

    // saturate at the top of the counter
    assign inc = (&rdata) ? rdata : rdata + 1'b1;

    assign clearing = (state_reg == ST_CLEAR);
    assign done     = (state_reg == ST_WAIT);
    assign op_pop   = (state_reg == ST_IDLE) && !op_empty;

    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg.bin[IW-1:0];
        wdata = inc;
        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            ST_WAIT:
            begin
                we = cur_reg.acc;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.accepted  = cur_reg.acc;
        result.bin_hit   = cur_reg.acc ? cur_reg.bin[HIT_W-1:0] : '0;
        if (!cur_reg.ok)
        begin
            result.bin_count = '0;
        end
        else if (cur_reg.acc)
        begin
            result.bin_count = RESULT_W'(inc);
        end
        else
        begin
            result.bin_count = RESULT_W'(rdata);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(TOTAL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!op_empty)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            cur_reg <= op;
        end
    end

endmodule

[design/event_cut_charge_histogram_unit.sv]
// Top level of the event cut charge histogram unit.
//
//   channel  signals                              direction  handshake
//   item     start, busy, item                    in         start && !busy
//   result   done, result                         out        done, one cycle
//   config   cfg_valid, cfg_ready, cfg_index,     in         cfg_valid && cfg_ready
//            cfg_data
//
// An event that passes the cuts with charge at or above hist_low is accepted, its bin
// is found and it is handed off; any other item is accepted and handed off. The back
// does one counter read-modify-write per item, reading the bin and then writing it,
// so the queue never fills. After reset all NUM_BINS+2 counters are cleared with busy
// high; configuration writes are taken throughout. The receiver cannot stall: each
// result shows for one cycle.
module event_cut_charge_histogram_unit #(
    parameter int NUM_BINS    = ech_pkg::DEF_NUM_BINS,
    parameter int BIN_WIDTH   = ech_pkg::DEF_BIN_WIDTH,
    parameter int COUNT_WIDTH = ech_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ech_pkg::ech_in_t                  item,
    output logic                              done,
    output ech_pkg::ech_out_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ech_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ech_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import ech_pkg::*;

    ech_cfg_t cfg_reg;
    ech_op_t  fq_op;
    ech_op_t  qb_op;
    logic     front_busy;
    logic     clearing;
    logic     op_push, op_full, op_pop, op_empty;

    assign cfg_ready = 1'b1;
    assign busy      = front_busy || clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wanted_channel  <= RST_WANTED_CHANNEL;
            cfg_reg.noise_limit     <= RST_NOISE_LIMIT;
            cfg_reg.baseline_center <= RST_BASELINE_CENTER;
            cfg_reg.baseline_window <= RST_BASELINE_WINDOW;
            cfg_reg.hist_low        <= RST_HIST_LOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WANTED_CHANNEL:  cfg_reg.wanted_channel  <= cfg_data[CHANNEL_W-1:0];
                CFG_NOISE_LIMIT:     cfg_reg.noise_limit     <= cfg_data[NOISE_W-1:0];
                CFG_BASELINE_CENTER: cfg_reg.baseline_center <= cfg_data[BASELINE_W-1:0];
                CFG_BASELINE_WINDOW: cfg_reg.baseline_window <= cfg_data[WINDOW_W-1:0];
                CFG_HIST_LOW:        cfg_reg.hist_low        <= cfg_data[CHARGE_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    ech_front #(
        .NUM_BINS  (NUM_BINS),
        .BIN_WIDTH (BIN_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start && !clearing),
        .busy    (front_busy),
        .item    (item),
        .cfg     (cfg_reg),
        .op      (fq_op),
        .op_push (op_push),
        .op_full (op_full)
    );

    ech_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (fq_op),
        .full  (op_full),
        .pop   (op_pop),
        .rdata (qb_op),
        .empty (op_empty)
    );

    ech_back #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (qb_op),
        .op_empty (op_empty),
        .op_pop   (op_pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

endmodule
